[hdl/multichannel_sliding_median_core_macros.svh]
// ----------------------------------------------------------------------------
// Sliding median core assertion macros
// Shared property templates, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_SLIDING_MEDIAN_CORE_MACROS_SVH
`define MULTICHANNEL_SLIDING_MEDIAN_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define MSM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger
`define MSM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/msm_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding median package
// Field widths, parameter defaults, sequencer states and control bundle.
// ----------------------------------------------------------------------------
package msm_pkg;

   // Parameter defaults
   localparam int NUM_CHANNELS_DEF = 5;
   localparam int MAX_WINDOW_DEF   = 7;
   localparam int SAMPLE_BITS_DEF  = 10;

   // Fixed request and response field widths
   localparam int CHANNEL_W   = 3;
   localparam int SAMPLE_W    = 10;
   localparam int LEN_FIELD_W = 3;
   localparam int MEDIAN_W    = 10;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SORT,
      ST_DONE
   } state_type;

   // Phase controls decoded from the sequencer state
   typedef struct packed {
      logic take_req;
      logic load_phase;
      logic sort_phase;
      logic done_phase;
   } ctrl_type;

endpackage

[hdl/msm_ram.sv]
// ----------------------------------------------------------------------------
// Sliding median window RAM
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module msm_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 35
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, register one read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/multichannel_sliding_median_core.sv]
// ----------------------------------------------------------------------------
// Multichannel sliding median core
// Per-channel circular sample windows with an upper-median pick per request.
// ----------------------------------------------------------------------------
//   port group | direction | contents
//   req_*      | in        | channel, sample, window_len (valid/ready)
//   rsp_*      | out       | median, channel_out (valid/ready)
//
// With L the clamped window length, one request passes from idle through a
// load of L window entries over the one RAM read port, then L - L/2 bubble
// passes on the single compare-exchange unit, then the done step. An
// out-of-range channel goes from idle straight to the done step. The done step
// can be held while the new write position is reduced modulo L.
// Reset is synchronous; it clears all entry valid flags (unwritten entries read as zero) and write positions.
// A finished median waits in the output register while the next request is
// taken; a stalled response only holds the core in its done step.
// ----------------------------------------------------------------------------
module multichannel_sliding_median_core #(
   parameter int NUM_CHANNELS = msm_pkg::NUM_CHANNELS_DEF,
   parameter int MAX_WINDOW   = msm_pkg::MAX_WINDOW_DEF,
   parameter int SAMPLE_BITS  = msm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [msm_pkg::CHANNEL_W-1:0]    req_channel,
   input  logic [msm_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic [msm_pkg::LEN_FIELD_W-1:0]  req_window_len,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [msm_pkg::MEDIAN_W-1:0]     rsp_median,
   output logic [msm_pkg::CHANNEL_W-1:0]    rsp_channel_out
);

   import msm_pkg::*;

   localparam int DEPTH  = NUM_CHANNELS * MAX_WINDOW;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int POS_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
   localparam int MOD_W  = POS_W + 1;
   localparam int LCW    = (LEN_W > LEN_FIELD_W) ? LEN_W : LEN_FIELD_W;
   localparam int SWIDE  = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int MWIDE  = (SAMPLE_BITS > MEDIAN_W) ? SAMPLE_BITS : MEDIAN_W;
   localparam int IDX1   = (MAX_WINDOW > 1) ? 1 : 0;

   state_type state_ff, state_in;
   ctrl_type  ctrl;

   logic                   req_fire;
   logic                   ch_oor;
   logic [CH_W-1:0]        ch_idx;
   logic [LCW-1:0]         len_wide;
   logic [LEN_W-1:0]       len_sel;
   logic [POS_W-1:0]       pos_rd;
   logic [POS_W-1:0]       pos_cl;
   logic [ADDR_W-1:0]      base_sel;
   logic [SWIDE-1:0]       sample_wide;
   logic [SAMPLE_BITS-1:0] sample_store;

   // Request context
   logic [CHANNEL_W-1:0]   chan_ff;
   logic [CH_W-1:0]        chi_ff;
   logic                   oor_ff;
   logic [LEN_W-1:0]       len_ff;
   logic [ADDR_W-1:0]      base_ff;
   logic [LEN_W-1:0]       passes;

   // Write position modulo reduction
   logic [MOD_W-1:0]       mod_ff, mod_in;
   logic                   mod_ge;

   // Window load
   logic [LEN_W-1:0]       rd_cnt_ff, rd_cnt_in;
   logic                   rd_issue;
   logic [ADDR_W-1:0]      rd_addr;
   logic                   pend_ff;
   logic [POS_W-1:0]       ld_idx_ff;
   logic                   rd_vld_ff;
   logic [SAMPLE_BITS-1:0] ram_q;
   logic [SAMPLE_BITS-1:0] ld_val;
   logic                   load_done;
   logic [DEPTH-1:0]       valid_ff;

   // Sort line and compare-exchange unit
   logic [SAMPLE_BITS-1:0] sort_ff [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] sort_in [MAX_WINDOW];
   logic [POS_W-1:0]       step_ff, step_in;
   logic [LEN_W-1:0]       pass_ff, pass_in;
   logic                   cx;
   logic                   sort_last;
   logic                   swap;
   logic [SAMPLE_BITS-1:0] cx_hi, cx_lo;

   // Result
   logic [POS_W-1:0]       mid_idx;
   logic [MWIDE-1:0]       mid_wide;
   logic                   done_go;
   logic [POS_W-1:0]       wpos_ff [NUM_CHANNELS];
   logic                   rsp_valid_ff;
   logic [MEDIAN_W-1:0]    rsp_median_ff;
   logic [CHANNEL_W-1:0]   rsp_chan_ff;

   // Decode the request
   assign req_fire = req_valid && ctrl.take_req;

   always_comb begin
      ch_oor   = (32'(req_channel) >= NUM_CHANNELS);
      ch_idx   = ch_oor ? '0 : CH_W'(req_channel);
      len_wide = LCW'(req_window_len);
      if (len_wide == '0) begin
         len_sel = LEN_W'(1);
      end else if (len_wide > LCW'(MAX_WINDOW)) begin
         len_sel = LEN_W'(MAX_WINDOW);
      end else begin
         len_sel = LEN_W'(len_wide);
      end
      pos_rd       = wpos_ff[ch_idx];
      pos_cl       = (32'(pos_rd) >= MAX_WINDOW) ? '0 : pos_rd;
      base_sel     = ADDR_W'(32'(ch_idx) * MAX_WINDOW);
      sample_wide  = SWIDE'(req_sample);
      sample_store = sample_wide[SAMPLE_BITS-1:0];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ch_oor ? ST_DONE : ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (load_done) begin
               state_in = ST_SORT;
            end
         end
         ST_SORT: begin
            if (sort_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (done_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Phase controls
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: ctrl.take_req   = 1'b1;
         ST_LOAD: ctrl.load_phase = 1'b1;
         ST_SORT: ctrl.sort_phase = 1'b1;
         ST_DONE: ctrl.done_phase = 1'b1;
         default: ctrl = '0;
      endcase
   end

   assign req_ready = ctrl.take_req;

   // Reduce the advanced write position modulo the window length
   always_comb begin
      mod_ge = (32'(mod_ff) >= 32'(len_ff));
      mod_in = mod_ff;
      if (req_fire) begin
         mod_in = MOD_W'(pos_cl) + MOD_W'(1);
      end else if (!ctrl.take_req && mod_ge) begin
         mod_in = mod_ff - MOD_W'(len_ff);
      end
   end

   // Issue window reads, one entry a cycle
   always_comb begin
      rd_issue  = ctrl.load_phase && (rd_cnt_ff < len_ff);
      rd_addr   = base_ff + ADDR_W'(rd_cnt_ff);
      rd_cnt_in = rd_cnt_ff;
      if (req_fire) begin
         rd_cnt_in = '0;
      end else if (rd_issue) begin
         rd_cnt_in = rd_cnt_ff + LEN_W'(1);
      end
      ld_val    = rd_vld_ff ? ram_q : '0;
      load_done = pend_ff && (32'(ld_idx_ff) + 1 == 32'(len_ff));
   end

   // Compare-exchange head pair
   always_comb begin
      swap  = sort_ff[0] > sort_ff[IDX1];
      cx_hi = swap ? sort_ff[0] : sort_ff[IDX1];
      cx_lo = swap ? sort_ff[IDX1] : sort_ff[0];
   end

   // Sequence bubble passes: L-1 exchange steps, then one plain rotate
   always_comb begin
      passes    = len_ff - (len_ff >> 1);
      cx        = ctrl.sort_phase && (32'(step_ff) + 1 < 32'(len_ff));
      sort_last = ctrl.sort_phase && !cx && (32'(pass_ff) + 1 == 32'(passes));
      step_in   = step_ff;
      pass_in   = pass_ff;
      if (req_fire) begin
         step_in = '0;
         pass_in = '0;
      end else if (cx) begin
         step_in = step_ff + POS_W'(1);
      end else if (ctrl.sort_phase) begin
         step_in = '0;
         pass_in = pass_ff + LEN_W'(1);
      end
   end

   // Rotate the active part of the sort line, load entries as they arrive
   always_comb begin
      for (int i = 0; i < MAX_WINDOW; i++) begin
         sort_in[i] = sort_ff[i];
         if (pend_ff && (32'(ld_idx_ff) == i)) begin
            sort_in[i] = ld_val;
         end else if (ctrl.sort_phase) begin
            if (i + 1 == 32'(len_ff)) begin
               sort_in[i] = cx ? cx_lo : sort_ff[0];
            end else if (i + 1 < 32'(len_ff)) begin
               sort_in[i] = (i == 0 && cx) ? cx_hi : sort_ff[(i + 1) % MAX_WINDOW];
            end
         end
      end
   end

   // Pick the median and decide when the result can move out
   always_comb begin
      mid_idx  = POS_W'(len_ff >> 1);
      mid_wide = MWIDE'(sort_ff[mid_idx]);
      done_go  = ctrl.done_phase && (oor_ff || !mod_ge) && (!rsp_valid_ff || rsp_ready);
   end

   msm_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (req_fire && !ch_oor),
      .wr_addr (base_sel + ADDR_W'(pos_cl)),
      .wr_data (sample_store),
      .rd_en   (rd_issue),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            wpos_ff[c] <= '0;
         end
      end else begin
         state_ff <= state_in;
         pend_ff  <= rd_issue;
         if (req_fire && !ch_oor) begin
            valid_ff[base_sel + ADDR_W'(pos_cl)] <= 1'b1;
         end
         if (done_go && !oor_ff) begin
            wpos_ff[chi_ff] <= POS_W'(mod_ff);
         end
         if (done_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         chan_ff <= req_channel;
         chi_ff  <= ch_idx;
         oor_ff  <= ch_oor;
         len_ff  <= len_sel;
         base_ff <= base_sel;
      end
      mod_ff    <= mod_in;
      rd_cnt_ff <= rd_cnt_in;
      ld_idx_ff <= POS_W'(rd_cnt_ff);
      rd_vld_ff <= valid_ff[rd_addr];
      step_ff   <= step_in;
      pass_ff   <= pass_in;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         sort_ff[i] <= sort_in[i];
      end
      if (done_go) begin
         rsp_median_ff <= oor_ff ? '0 : mid_wide[MEDIAN_W-1:0];
         rsp_chan_ff   <= chan_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_median      = rsp_median_ff;
   assign rsp_channel_out = rsp_chan_ff;

   `include "multichannel_sliding_median_core_macros.svh"

   `MSM_ASSERT_NEXT(a_accept_starts, req_fire, state_ff == ST_LOAD || state_ff == ST_DONE, "request did not start a load or a done step")
   `MSM_ASSERT_NOW(a_sort_bounds, state_ff == ST_SORT, (32'(step_ff) < 32'(len_ff)) && (32'(pass_ff) < 32'(passes)), "sort counters out of window")
   `MSM_ASSERT_NOW(a_load_index, pend_ff, 32'(ld_idx_ff) < 32'(len_ff), "loaded entry beyond window length")
   `MSM_ASSERT_NEXT(a_result_shows, done_go, rsp_valid, "finished median not presented")

endmodule

[tb/sv/multichannel_sliding_median_core_test.sv]
// ----------------------------------------------------------------------------
// Sliding median core testbench
// Drives tagged samples with random gaps and response stalls, predicts each
// channel's window median in a scoreboard and compares every response.
// ----------------------------------------------------------------------------
module multichannel_sliding_median_core_test;

   import msm_pkg::*;

   localparam int NUM_CH         = NUM_CHANNELS_DEF;
   localparam int WIN_DEPTH      = MAX_WINDOW_DEF;
   localparam int RANDOM_ITEMS   = 1350;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 60;

   typedef logic [CHANNEL_W-1:0]   channel_type;
   typedef logic [SAMPLE_W-1:0]    sample_type;
   typedef logic [LEN_FIELD_W-1:0] len_field_type;
   typedef logic [MEDIAN_W-1:0]    median_type;

   typedef struct {
      median_type  median;
      channel_type channel;
   } median_result_type;

   // Window predictor and store of pending medians
   class median_scoreboard;
      sample_type        window[NUM_CH][WIN_DEPTH];
      int unsigned       wr_pos[NUM_CH];
      median_result_type pending_medians[$];
      int                failures;

      function new();
         foreach (window[c, i]) window[c][i] = '0;
         foreach (wr_pos[c]) wr_pos[c] = 0;
         failures = 0;
      endfunction

      // Update the channel window and queue the median it now yields
      function void note_request(channel_type ch, sample_type smp,
                                 len_field_type len_field);
         median_result_type res;
         int unsigned       eff_len;
         int unsigned       pos;
         sample_type        vals[$];
         res.channel = ch;
         res.median  = '0;
         if (ch < NUM_CH) begin
            eff_len = (len_field == 0) ? 1 : 32'(len_field);
            if (eff_len > WIN_DEPTH) eff_len = WIN_DEPTH;
            pos = wr_pos[ch];
            if (pos >= WIN_DEPTH) pos = 0;
            window[ch][pos] = smp;
            wr_pos[ch] = (pos + 1) % eff_len;
            for (int i = 0; i < eff_len; i++) vals.push_back(window[ch][i]);
            vals.sort();
            res.median = vals[eff_len / 2];
         end
         pending_medians.push_back(res);
      endfunction

      // Compare a response against the oldest pending median
      function void check_response(median_type median, channel_type ch);
         median_result_type exp_res;
         if (pending_medians.size() == 0) begin
            $error("response with no request pending: median %0d channel_out %0d",
                   median, ch);
            failures++;
         end else begin
            exp_res = pending_medians.pop_front();
            if (median !== exp_res.median) begin
               $error("median: expected %0d, actual %0d", exp_res.median, median);
               failures++;
            end
            if (ch !== exp_res.channel) begin
               $error("channel_out: expected %0d, actual %0d", exp_res.channel, ch);
               failures++;
            end
         end
      endfunction

      function int pending();
         return pending_medians.size();
      endfunction
   endclass

   logic          clock          = 1'b0;
   logic          reset          = 1'b1;
   logic          req_valid      = 1'b0;
   logic          req_ready;
   channel_type   req_channel    = '0;
   sample_type    req_sample     = '0;
   len_field_type req_window_len = '0;
   logic          rsp_valid;
   logic          rsp_ready      = 1'b0;
   median_type    rsp_median;
   channel_type   rsp_channel_out;

   median_scoreboard sb;
   bit               steady_flow = 1'b0;
   int               rsp_stall_left = 0;
   int               quiet_cycles = 0;

   multichannel_sliding_median_core DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .req_window_len  (req_window_len),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_median      (rsp_median),
      .rsp_channel_out (rsp_channel_out)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mostly short idle stretches, now and then a long one
   function automatic int idle_cycles();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Stall the response side at random
   always @(posedge clock) begin
      if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_stall_left = idle_cycles();
         rsp_ready <= (rsp_stall_left == 0);
         if (rsp_stall_left > 0) rsp_stall_left--;
      end
   end

   // Observe both handshakes and guard against a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_channel, req_sample, req_window_len);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_median, rsp_channel_out);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("multichannel_sliding_median_core_test failed");
            $finish;
         end
      end
   end

   // Present one request after a random gap and hold it until taken
   task automatic send_request(channel_type ch, sample_type smp, len_field_type len_field);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_channel    <= ch;
      req_sample     <= smp;
      req_window_len <= len_field;
      do @(posedge clock); while (!req_ready);
   endtask

   // Extremes, out-of-range channels, length clamping and a stale position
   task automatic run_directed();
      sample_type ch3_samples[7] = '{10'd1023, 10'd512, 10'd1, 10'd1000, 10'd3, 10'd700,
                                     10'd341};
      sample_type ch4_samples[5] = '{10'd1023, 10'd682, 10'd341, 10'd1020, 10'd5};
      send_request(3'd0, 10'd0, 3'd1);
      send_request(3'd0, 10'd1023, 3'd1);
      send_request(3'd0, 10'd1023, 3'd7);
      send_request(3'd1, 10'd1023, 3'd0);
      send_request(3'd5, 10'd777, 3'd3);
      send_request(3'd6, 10'd1023, 3'd7);
      send_request(3'd7, 10'd0, 3'd0);
      send_request(3'd2, 10'd100, 3'd2);
      send_request(3'd2, 10'd50, 3'd2);
      foreach (ch3_samples[i]) send_request(3'd3, ch3_samples[i], 3'd7);
      // leave the position past the shorter length used next
      foreach (ch4_samples[i]) send_request(3'd4, ch4_samples[i], 3'd7);
      send_request(3'd4, 10'd9, 3'd2);
      send_request(3'd4, 10'd1010, 3'd4);
   endtask

   // Channels mostly keep a length for a while so windows fill with real data
   task automatic run_random();
      len_field_type pref_len[NUM_CH];
      channel_type   ch;
      sample_type    smp;
      len_field_type len_field;
      foreach (pref_len[c]) pref_len[c] = len_field_type'($urandom_range(1, 7));
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 200 == 100) steady_flow = 1'b1;
         if (n % 200 == 150) steady_flow = 1'b0;
         ch = ($urandom_range(0, 9) == 0) ? channel_type'($urandom_range(NUM_CH, 7))
                                          : channel_type'($urandom_range(0, NUM_CH - 1));
         if (ch < NUM_CH && $urandom_range(0, 19) == 0) begin
            pref_len[ch] = len_field_type'($urandom_range(1, 7));
         end
         if (ch < NUM_CH && $urandom_range(0, 99) < 85) len_field = pref_len[ch];
         else len_field = len_field_type'($urandom_range(0, 7));
         case ($urandom_range(0, 9))
            0: smp = 10'd0;
            1: smp = 10'd1023;
            default: smp = sample_type'($urandom_range(0, 1023));
         endcase
         send_request(ch, smp, len_field);
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      req_valid <= 1'b0;
      // drain outstanding medians, then watch for strays
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0) $display("multichannel_sliding_median_core_test passed");
      else $display("multichannel_sliding_median_core_test failed");
      $finish;
   end

endmodule
